/* src/watchdog_timer_registers_top_defines.svh */
// ----------------------------------------------------------------------------
// Watchdog timer registers: assertion macros
// Shared property forms for the port-level checks of the watchdog block.
// ----------------------------------------------------------------------------
`ifndef WATCHDOG_TIMER_REGISTERS_TOP_DEFINES_SVH
`define WATCHDOG_TIMER_REGISTERS_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is held
`define WDTR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wdtr check failed");

// Next-cycle implication, masked while reset is held
`define WDTR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wdtr check failed");

// Next-cycle implication that also holds across reset
`define WDTR_ASSERT_NEXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("wdtr check failed");

`endif

/* src/wdtr_pkg.sv */
// ----------------------------------------------------------------------------
// Watchdog timer registers: package
// Field widths, command and offset codes, control bits and reset constants.
// ----------------------------------------------------------------------------
package wdtr_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned KEY_W  = 16;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [KEY_W-1:0]  key_t;

  // Item commands; the fourth code does nothing
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  // Word offsets of the register map
  typedef enum logic [IDX_W-1:0] {
    OFS_COUNTER  = 3'd0,
    OFS_LOAD     = 3'd1,
    OFS_RESTART  = 3'd2,
    OFS_CONTROL  = 3'd3,
    OFS_STATUS   = 3'd4,
    OFS_STAT_CLR = 3'd5,
    OFS_REVISION = 3'd7
  } reg_idx_t;

  // Control word bits
  localparam int unsigned CTL_ENABLE_BIT = 0;
  localparam int unsigned CTL_SYSRST_BIT = 1;
  localparam int unsigned CTL_IRQEN_BIT  = 2;

  // Status clear bit
  localparam int unsigned STAT_CLR_BIT = 0;

  localparam data_t REVISION_WORD = 32'h0001_0601;
  localparam data_t LOAD_AT_RESET = 32'h03EF_1480;
  localparam key_t  KEY_AT_RESET  = 16'h5AB9;

endpackage

/* src/watchdog_timer_registers_top.sv */
// ----------------------------------------------------------------------------
// Watchdog timer registers: top level
// Accepted words go through the input stage into the result registers, which
// load when empty or being taken; one word per cycle while out_ready is high.
// Rate is set by the combinational state update between input and result regs.
// Synchronous active-low reset restores control and state regs; no clearing pass.
// ----------------------------------------------------------------------------
module watchdog_timer_registers_top #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration port
  input  logic                   cfg_write_en,
  input  wdtr_pkg::key_t         cfg_write_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_cmd,
  input  wdtr_pkg::idx_t         in_reg_index,
  input  wdtr_pkg::data_t        in_write_data,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output wdtr_pkg::data_t        out_read_data,
  output logic                   out_irq_level,
  output logic                   out_reset_pulse
);
  import wdtr_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};
  localparam data_t                  COUNT_MAX_W = data_t'(COUNT_MAX);
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE   = COUNT_WIDTH'(1);

  // input stage
  logic            s1_valid_r;
  logic [1:0]      s1_cmd_r;
  idx_t            s1_idx_r;
  data_t           s1_data_r;

  // watchdog state
  key_t                   key_r;
  data_t                  load_r, load_nxt;
  data_t                  ctl_r, ctl_nxt;
  logic                   expired_r, expired_nxt;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic                   running_r, running_nxt;
  logic                   armed_r, armed_nxt;

  // result stage
  logic            out_valid_r, out_valid_nxt;
  data_t           rd_r, rd_nxt;
  logic            irq_r, irq_nxt;
  logic            pulse_r, pulse_nxt;

  logic                   s2_adv;
  logic [COUNT_WIDTH-1:0] reload_val;
  logic [COUNT_WIDTH-1:0] rem_dec;
  data_t                  rem_w;
  data_t                  counter_view;

  // Advance a word into the result register when it is empty or being taken
  assign s2_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_adv;

  // Reload value: max(load, 1), saturated to the counter width
  always_comb begin
    if (load_r == '0) begin
      reload_val = COUNT_ONE;
    end else if (load_r > COUNT_MAX_W) begin
      reload_val = COUNT_MAX;
    end else begin
      reload_val = load_r[COUNT_WIDTH-1:0];
    end
  end

  assign rem_dec      = rem_r - COUNT_ONE;
  assign rem_w        = data_t'(rem_r);
  assign counter_view = ctl_r[CTL_ENABLE_BIT] ?
                        ((rem_w < load_r) ? rem_w : load_r) : load_r;

  // Apply the held word to the state and form its result
  always_comb begin
    load_nxt    = load_r;
    ctl_nxt     = ctl_r;
    expired_nxt = expired_r;
    rem_nxt     = rem_r;
    running_nxt = running_r;
    armed_nxt   = armed_r;
    rd_nxt      = '0;
    pulse_nxt   = 1'b0;
    unique case (s1_cmd_r)
      CMD_TICK: begin
        if (armed_r) begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            armed_nxt   = 1'b0;
            expired_nxt = 1'b1;
            pulse_nxt   = ctl_r[CTL_SYSRST_BIT];
          end
        end
      end
      CMD_READ: begin
        unique case (s1_idx_r)
          OFS_COUNTER:  rd_nxt = counter_view;
          OFS_LOAD:     rd_nxt = load_r;
          OFS_CONTROL:  rd_nxt = ctl_r;
          OFS_STATUS:   rd_nxt = data_t'(expired_r);
          OFS_REVISION: rd_nxt = REVISION_WORD;
          default:      rd_nxt = '0;
        endcase
      end
      CMD_WRITE: begin
        unique case (s1_idx_r)
          OFS_LOAD: load_nxt = s1_data_r;
          OFS_RESTART: begin
            if (ctl_r[CTL_ENABLE_BIT] && (s1_data_r == data_t'(key_r))) begin
              rem_nxt   = reload_val;
              armed_nxt = 1'b1;
            end
          end
          OFS_CONTROL: begin
            ctl_nxt = s1_data_r;
            if (s1_data_r[CTL_ENABLE_BIT]) begin
              if (!running_r) begin
                running_nxt = 1'b1;
                rem_nxt     = reload_val;
                armed_nxt   = 1'b1;
              end
            end else begin
              running_nxt = 1'b0;
              armed_nxt   = 1'b0;
            end
          end
          OFS_STAT_CLR: begin
            if (s1_data_r[STAT_CLR_BIT]) begin
              expired_nxt = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    irq_nxt = expired_nxt && ctl_nxt[CTL_IRQEN_BIT];
  end

  // Hold the result until taken, drop valid once taken
  always_comb begin
    if (s2_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      key_r       <= KEY_AT_RESET;
      load_r      <= LOAD_AT_RESET;
      ctl_r       <= '0;
      expired_r   <= 1'b0;
      rem_r       <= '0;
      running_r   <= 1'b0;
      armed_r     <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en) begin
        key_r <= cfg_write_data;
      end
      if (s2_adv) begin
        load_r    <= load_nxt;
        ctl_r     <= ctl_nxt;
        expired_r <= expired_nxt;
        rem_r     <= rem_nxt;
        running_r <= running_nxt;
        armed_r   <= armed_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r  <= in_cmd;
      s1_idx_r  <= in_reg_index;
      s1_data_r <= in_write_data;
    end
    if (s2_adv) begin
      rd_r    <= rd_nxt;
      irq_r   <= irq_nxt;
      pulse_r <= pulse_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = rd_r;
  assign out_irq_level   = irq_r;
  assign out_reset_pulse = pulse_r;

endmodule

/* src/wdtr_checker.sv */
// ----------------------------------------------------------------------------
// Watchdog timer registers: port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`include "watchdog_timer_registers_top_defines.svh"

module wdtr_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input wdtr_pkg::data_t        out_read_data,
  input logic                   out_irq_level,
  input logic                   out_reset_pulse
);
  import wdtr_pkg::*;

  // Reset empties the result register
  `WDTR_ASSERT_NEXT_RST(a_rst_clears_out, !rst_n, !out_valid)

  // A stalled word stays offered
  `WDTR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A stalled word keeps its payload
  `WDTR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
    $stable(out_read_data) && $stable(out_irq_level) && $stable(out_reset_pulse))

  // A reset pulse only comes from a tick, which reads nothing
  `WDTR_ASSERT_NOW(a_pulse_no_data, out_valid && out_reset_pulse, out_read_data == '0)

endmodule

bind watchdog_timer_registers_top wdtr_checker u_wdtr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_data  (out_read_data),
  .out_irq_level  (out_irq_level),
  .out_reset_pulse(out_reset_pulse)
);

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Watchdog timer registers: block-level testbench
// Sends tick, read and write words through the input channel with random
// gaps, predicts every reply from a behavioural copy of the watchdog state,
// and checks each reply field by field while the output side stalls at random.
// The restart key is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;

  import wdtr_pkg::*;

  // Command code with no effect and the unmapped word offset
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;
  localparam idx_t             OFS_SPARE = 3'd6;

  localparam int unsigned RANDOM_PER_PHASE = 360;
  localparam int unsigned SETTLE_CYCLES    = 4;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    idx_t             idx;
    data_t            data;
  } bus_word_t;

  typedef struct packed {
    data_t rdata;
    logic  irq;
    logic  pulse;
  } reply_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_write_en = 1'b0;
  key_t  cfg_write_data = '0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  logic [CMD_W-1:0] in_cmd = '0;
  idx_t  in_reg_index = '0;
  data_t in_write_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  data_t out_read_data;
  logic  out_irq_level;
  logic  out_reset_pulse;

  watchdog_timer_registers_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_reg_index    (in_reg_index),
    .in_write_data   (in_write_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_irq_level   (out_irq_level),
    .out_reset_pulse (out_reset_pulse)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted watchdog state
  key_t  wd_key = KEY_AT_RESET;
  data_t wd_load = LOAD_AT_RESET;
  data_t wd_ctrl = '0;
  logic  wd_expired = 1'b0;
  data_t wd_remaining = '0;
  logic  wd_running = 1'b0;
  logic  wd_armed = 1'b0;

  bus_word_t words_to_send[$];
  reply_t    responses_due[$];
  bus_word_t next_word;
  reply_t    want;

  int words_queued = 0;
  int words_taken = 0;
  int replies_seen = 0;
  int faults = 0;
  int expiries = 0;
  int pulses = 0;
  int reloads = 0;
  int keys_used = 1;

  int send_gap = 0;
  int send_streak = 0;
  bit send_calm = 1'b0;
  int recv_stall = 0;
  int recv_streak = 0;
  bit recv_calm = 1'b0;

  // Idle cycles before the next word; runs of zero-idle stretches now and then
  function automatic int draw_wait(inout int streak, inout bit calm);
    if (streak == 0) begin
      streak = $urandom_range(10, 60);
      calm = ($urandom_range(0, 3) == 0);
    end
    streak--;
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic void wd_reload();
    wd_remaining = (wd_load == '0) ? data_t'(1) : wd_load;
    wd_armed = 1'b1;
    reloads++;
  endfunction

  // Advance the watchdog by one word and work out its reply
  function automatic reply_t watchdog_apply(input bus_word_t w);
    reply_t r;
    r = '0;
    if (w.cmd == CMD_TICK) begin
      if (wd_armed) begin
        wd_remaining = wd_remaining - 1'b1;
        if (wd_remaining == '0) begin
          wd_armed = 1'b0;
          wd_expired = 1'b1;
          expiries++;
          if (wd_ctrl[CTL_SYSRST_BIT]) begin
            r.pulse = 1'b1;
            pulses++;
          end
        end
      end
    end else if (w.cmd == CMD_READ) begin
      case (w.idx)
        OFS_COUNTER: begin
          if (wd_ctrl[CTL_ENABLE_BIT])
            r.rdata = (wd_remaining < wd_load) ? wd_remaining : wd_load;
          else
            r.rdata = wd_load;
        end
        OFS_LOAD:     r.rdata = wd_load;
        OFS_CONTROL:  r.rdata = wd_ctrl;
        OFS_STATUS:   r.rdata = data_t'(wd_expired);
        OFS_REVISION: r.rdata = REVISION_WORD;
        default:      r.rdata = '0;
      endcase
    end else if (w.cmd == CMD_WRITE) begin
      case (w.idx)
        OFS_LOAD: wd_load = w.data;
        OFS_RESTART: begin
          if (wd_ctrl[CTL_ENABLE_BIT] && w.data == data_t'(wd_key))
            wd_reload();
        end
        OFS_CONTROL: begin
          wd_ctrl = w.data;
          if (w.data[CTL_ENABLE_BIT]) begin
            if (!wd_running) begin
              wd_running = 1'b1;
              wd_reload();
            end
          end else begin
            wd_running = 1'b0;
            wd_armed = 1'b0;
          end
        end
        OFS_STAT_CLR: begin
          if (w.data[STAT_CLR_BIT])
            wd_expired = 1'b0;
        end
        default: ;
      endcase
    end
    r.irq = wd_expired & wd_ctrl[CTL_IRQEN_BIT];
    return r;
  endfunction

  // Driver: present queued words, predict each one as it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        responses_due.push_back(watchdog_apply({in_cmd, in_reg_index, in_write_data}));
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (words_to_send.size() > 0) begin
          next_word = words_to_send.pop_front();
          in_valid <= 1'b1;
          in_cmd <= next_word.cmd;
          in_reg_index <= next_word.idx;
          in_write_data <= next_word.data;
          send_gap = draw_wait(send_streak, send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each reply with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        replies_seen++;
        if (responses_due.size() == 0) begin
          $display("%0t reply with nothing outstanding: read_data %h irq %b pulse %b",
                   $time, out_read_data, out_irq_level, out_reset_pulse);
          faults++;
        end else begin
          want = responses_due.pop_front();
          if (out_read_data !== want.rdata) begin
            $display("%0t read_data expected %h got %h", $time, want.rdata, out_read_data);
            faults++;
          end
          if (out_irq_level !== want.irq) begin
            $display("%0t irq_level expected %b got %b", $time, want.irq, out_irq_level);
            faults++;
          end
          if (out_reset_pulse !== want.pulse) begin
            $display("%0t reset_pulse expected %b got %b", $time, want.pulse,
                     out_reset_pulse);
            faults++;
          end
        end
        recv_stall = draw_wait(recv_streak, recv_calm);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_word(input logic [CMD_W-1:0] cmd, input idx_t idx,
                            input data_t data);
    words_to_send.push_back({cmd, idx, data});
    words_queued++;
  endtask

  // Hold until every word is taken and answered, then let the pipe drain
  task automatic settle();
    while (words_taken != words_queued || responses_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_restart_key(input key_t k);
    settle();
    cfg_write_en <= 1'b1;
    cfg_write_data <= k;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    wd_key = k;
    keys_used++;
  endtask

  // Mostly short timeouts so that expiry happens often
  function automatic data_t pick_load();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom;
      2:       return $urandom_range(25, 300);
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  task automatic queue_random_word();
    int pick;
    data_t d;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      queue_word(CMD_TICK, idx_t'($urandom_range(0, 7)), $urandom);
    end else if (pick < 62) begin
      queue_word(CMD_READ, idx_t'($urandom_range(0, 7)), $urandom);
    end else if (pick < 68) begin
      queue_word(CMD_WRITE, OFS_RESTART, data_t'(wd_key));
    end else if (pick < 70) begin
      // right key in the low half, junk above it
      d = {16'($urandom_range(1, 16'hFFFF)), wd_key};
      queue_word(CMD_WRITE, OFS_RESTART, d);
    end else if (pick < 73) begin
      queue_word(CMD_WRITE, OFS_RESTART, $urandom);
    end else if (pick < 78) begin
      d = $urandom;
      d[STAT_CLR_BIT] = ($urandom_range(0, 3) != 0);
      queue_word(CMD_WRITE, OFS_STAT_CLR, d);
    end else if (pick < 84) begin
      d = $urandom;
      d[CTL_ENABLE_BIT] = ($urandom_range(0, 4) != 0);
      queue_word(CMD_WRITE, OFS_CONTROL, d);
    end else if (pick < 87) begin
      queue_word(CMD_WRITE, OFS_LOAD, pick_load());
    end else begin
      queue_word(CMD_W'($urandom_range(0, 3)), idx_t'($urandom_range(0, 7)), $urandom);
    end
  endtask

  // Program a timeout, arm it, then run a mixed stream against it
  task automatic queue_episode();
    data_t d;
    queue_word(CMD_WRITE, OFS_LOAD, pick_load());
    if ($urandom_range(0, 2) == 0) begin
      d = $urandom;
      d[CTL_ENABLE_BIT] = 1'b0;
      queue_word(CMD_WRITE, OFS_CONTROL, d);
    end
    d = $urandom;
    d[CTL_ENABLE_BIT] = 1'b1;
    queue_word(CMD_WRITE, OFS_CONTROL, d);
    repeat ($urandom_range(15, 60)) queue_random_word();
  endtask

  task automatic queue_phase();
    int stop_at;
    stop_at = words_queued + RANDOM_PER_PHASE;
    // a correct and a nearly correct restart at the start of every phase
    queue_word(CMD_WRITE, OFS_CONTROL, data_t'(7));
    queue_word(CMD_WRITE, OFS_RESTART, {16'hFFFF, wd_key});
    queue_word(CMD_WRITE, OFS_RESTART, data_t'(wd_key));
    while (words_queued < stop_at) queue_episode();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: register map, undefined offsets and commands
    queue_word(CMD_READ, OFS_REVISION, '0);
    queue_word(CMD_READ, OFS_COUNTER, '0);
    queue_word(CMD_READ, OFS_LOAD, '0);
    queue_word(CMD_READ, OFS_CONTROL, '0);
    queue_word(CMD_READ, OFS_STATUS, '0);
    queue_word(CMD_READ, OFS_RESTART, '0);
    queue_word(CMD_READ, OFS_STAT_CLR, '0);
    queue_word(CMD_READ, OFS_SPARE, '0);
    queue_word(CMD_NONE, OFS_CONTROL, '1);
    // restart while disabled must not arm
    queue_word(CMD_WRITE, OFS_LOAD, data_t'(3));
    queue_word(CMD_WRITE, OFS_RESTART, data_t'(wd_key));
    // enable with every control bit set, count down to expiry
    queue_word(CMD_WRITE, OFS_CONTROL, '1);
    queue_word(CMD_TICK, OFS_COUNTER, '0);
    queue_word(CMD_READ, OFS_COUNTER, '0);
    queue_word(CMD_TICK, OFS_COUNTER, '0);
    queue_word(CMD_TICK, OFS_COUNTER, '0);
    queue_word(CMD_READ, OFS_COUNTER, '0);
    // restart after expiry still reloads; clear status only with bit zero
    queue_word(CMD_WRITE, OFS_RESTART, {16'hFFFF, wd_key});
    queue_word(CMD_WRITE, OFS_RESTART, data_t'(wd_key));
    queue_word(CMD_WRITE, OFS_STAT_CLR, 32'hFFFF_FFFE);
    queue_word(CMD_WRITE, OFS_STAT_CLR, data_t'(1));
    // zero load reloads as one tick
    queue_word(CMD_WRITE, OFS_LOAD, '0);
    queue_word(CMD_WRITE, OFS_CONTROL, '0);
    queue_word(CMD_WRITE, OFS_CONTROL, data_t'(1));
    queue_word(CMD_TICK, OFS_COUNTER, '0);
    // writes to read-only and unmapped offsets are dropped, then a full-scale load
    queue_word(CMD_WRITE, OFS_COUNTER, '1);
    queue_word(CMD_WRITE, OFS_STATUS, '1);
    queue_word(CMD_WRITE, OFS_SPARE, '1);
    queue_word(CMD_WRITE, OFS_REVISION, '1);
    queue_word(CMD_WRITE, OFS_LOAD, '1);

    queue_phase();
    set_restart_key(16'hFFFF);
    queue_phase();
    set_restart_key(16'h0000);
    queue_phase();
    set_restart_key(key_t'($urandom));
    queue_phase();
    set_restart_key(KEY_AT_RESET);
    queue_phase();

    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d words, checked %0d replies under %0d restart keys.",
             words_taken, replies_seen, keys_used);
    $display("Saw %0d counter reloads, %0d expiries, %0d reset pulses; %0d mismatches.",
             reloads, expiries, pulses, faults);
    if (faults == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog for the run itself
  initial begin
    #2000000;
    $display("Run timed out with %0d words taken of %0d and %0d replies outstanding",
             words_taken, words_queued, responses_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
